>>> rtl/sli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

   // coordinate width and derived datapath widths
   localparam int CW = 16;              // coordinate
   localparam int DW = CW + 1;          // coordinate difference
   localparam int PW = 2 * DW;          // product of two differences
   localparam int SW = PW + 1;          // den, tn, un
   localparam int NW = SW + DW;         // tn * d1
   localparam int TW = 16;              // tolerance, Q0.16
   localparam int HW = SW + TW + 1;     // range compare
   localparam int QB = CW + 2;          // quotient bits kept
   localparam int RW = SW + QB + 1;     // divider remainder
   localparam int VW = QB + 2;          // point before saturation

   localparam int REQ_W = 8 * CW;
   localparam int RSP_FW = 2 + 2 * CW;
   localparam int RSP_W = ((RSP_FW + 7) / 8) * 8;

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-3:0] REG_TOLERANCE = '0;
   localparam logic [TW-1:0] TOL_RESET = TW'(66);

   // pipeline length: seven front stages, quotient stages, output register
   localparam int NV = 8 + QB;

   typedef struct packed {
      logic          par;
      logic          hit;
      logic          negx;
      logic          negy;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
   } side_type;

endpackage

`default_nettype wire

>>> rtl/sli_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// quot = num / (2*den); a set top bit flags a quotient out of point range.
module sli_div (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [sli_pkg::RW-1:0]     num,
   input  wire logic [sli_pkg::SW-2:0]     den,
   output logic      [sli_pkg::QB-1:0]     quot
);
   import sli_pkg::*;

   logic [RW-1:0]   r_ff [QB];
   logic [QB-1:0]   q_ff [QB];
   logic [SW-2:0]   d_ff [QB];

   genvar i;
   generate
      for (i = 0; i < QB; i++) begin : g_stage
         logic [RW-1:0] r_prev;
         logic [QB-1:0] q_prev;
         logic [SW-2:0] d_prev;
         logic [RW-1:0] shifted;
         logic [RW-1:0] r_in;
         logic [QB-1:0] q_in;

         if (i == 0) begin : g_first
            assign r_prev = num;
            assign q_prev = '0;
            assign d_prev = den;
         end else begin : g_next
            assign r_prev = r_ff[i-1];
            assign q_prev = q_ff[i-1];
            assign d_prev = d_ff[i-1];
         end

         // 2*den aligned to quotient bit QB-1-i
         assign shifted = RW'({d_prev, 1'b0}) << (QB - 1 - i);

         always_comb begin
            if (r_prev >= shifted) begin
               r_in = r_prev - shifted;
               q_in = {q_prev[QB-2:0], 1'b1};
            end else begin
               r_in = r_prev;
               q_in = {q_prev[QB-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[i] <= r_in;
               q_ff[i] <= q_in;
               d_ff[i] <= d_prev;
            end
         end
      end
   endgenerate

   assign quot = q_ff[QB-1];

endmodule

`default_nettype wire

>>> rtl/segment_line_intersection.sv
`timescale 1ns / 1ps
`default_nettype none

// Segment/segment intersection, one pair per cycle. With P, Q the first
// segment's ends and A, B the second's, the block forms den, tn and un with
// exact integer arithmetic and reports hit when t = tn/den and u = un/den
// both lie in [-tol, 1+tol] (tol in Q0.16, register at address 0, reset 66),
// plus the point P - round(tn*(P-Q)/den), halves away from zero, saturated.
// A zero den gives parallel = 1, hit = 0 and point (0,0). Throughput is one
// transfer per clock while the pipe does not hold. The pipe runs from input
// transfer to result through seven arithmetic stages (differences, products,
// sums, sign fix, tolerance/offset products, range compare, dividend), 18
// stages of a bit-per-stage divider per coordinate, and the output register.
// The whole pipe holds when the output register is full and not taken.
module segment_line_intersection (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
   // line_start_x, line_start_y, line_end_x, line_end_y (16 bits each)
   input  wire logic [sli_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // hit, parallel, point_x (16), point_y (16), zero pad
   output logic      [sli_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [sli_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic      [31:0]                 csr_prdata,
   output logic                             csr_pready
);
   import sli_pkg::*;

   // ---------------- configuration ----------------
   logic [TW-1:0] tol_ff;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[CSR_AW-1:2] == REG_TOLERANCE) begin
         tol_ff <= csr_pwdata[TW-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_TOLERANCE) ? 32'(tol_ff) : '0;

   // ---------------- flow control ----------------
   // one enable for the whole pipe; valid bits ride along
   logic          en;
   logic [NV-1:0] val_ff;

   assign en         = !val_ff[NV-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= '0;
      end else if (en) begin
         val_ff <= {val_ff[NV-2:0], req_tvalid};
      end
   end

   // ---------------- stage 1: differences ----------------
   logic signed [CW-1:0] px, py, qx, qy, ax, ay, bx, by;
   assign px = req_tdata[0*CW +: CW];
   assign py = req_tdata[1*CW +: CW];
   assign qx = req_tdata[2*CW +: CW];
   assign qy = req_tdata[3*CW +: CW];
   assign ax = req_tdata[4*CW +: CW];
   assign ay = req_tdata[5*CW +: CW];
   assign bx = req_tdata[6*CW +: CW];
   assign by = req_tdata[7*CW +: CW];

   logic signed [CW-1:0] s1_px_ff, s1_py_ff;
   logic signed [DW-1:0] s1_d1x_ff, s1_d1y_ff, s1_d2x_ff, s1_d2y_ff, s1_ex_ff, s1_ey_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_px_ff  <= px;
         s1_py_ff  <= py;
         s1_d1x_ff <= DW'(px) - DW'(qx);
         s1_d1y_ff <= DW'(py) - DW'(qy);
         s1_d2x_ff <= DW'(ax) - DW'(bx);
         s1_d2y_ff <= DW'(ay) - DW'(by);
         s1_ex_ff  <= DW'(px) - DW'(ax);
         s1_ey_ff  <= DW'(py) - DW'(ay);
      end
   end

   // ---------------- stage 2: cross products ----------------
   logic signed [CW-1:0] s2_px_ff, s2_py_ff;
   logic signed [DW-1:0] s2_d1x_ff, s2_d1y_ff;
   logic signed [PW-1:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff, s2_e_ff, s2_f_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_px_ff  <= s1_px_ff;
         s2_py_ff  <= s1_py_ff;
         s2_d1x_ff <= s1_d1x_ff;
         s2_d1y_ff <= s1_d1y_ff;
         s2_a_ff   <= s1_d1x_ff * s1_d2y_ff;
         s2_b_ff   <= s1_d1y_ff * s1_d2x_ff;
         s2_c_ff   <= s1_ex_ff * s1_d2y_ff;
         s2_d_ff   <= s1_ey_ff * s1_d2x_ff;
         s2_e_ff   <= s1_d1y_ff * s1_ex_ff;
         s2_f_ff   <= s1_d1x_ff * s1_ey_ff;
      end
   end

   // ---------------- stage 3: den, tn, un ----------------
   logic signed [CW-1:0] s3_px_ff, s3_py_ff;
   logic signed [DW-1:0] s3_d1x_ff, s3_d1y_ff;
   logic signed [SW-1:0] s3_den_ff, s3_tn_ff, s3_un_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_px_ff  <= s2_px_ff;
         s3_py_ff  <= s2_py_ff;
         s3_d1x_ff <= s2_d1x_ff;
         s3_d1y_ff <= s2_d1y_ff;
         s3_den_ff <= SW'(s2_a_ff) - SW'(s2_b_ff);
         s3_tn_ff  <= SW'(s2_c_ff) - SW'(s2_d_ff);
         s3_un_ff  <= SW'(s2_e_ff) - SW'(s2_f_ff);
      end
   end

   // ---------------- stage 4: make den positive ----------------
   logic signed [CW-1:0] s4_px_ff, s4_py_ff;
   logic signed [DW-1:0] s4_d1x_ff, s4_d1y_ff;
   logic signed [SW-1:0] s4_den_ff, s4_tn_ff, s4_un_ff;
   logic                 s4_par_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s4_px_ff  <= s3_px_ff;
         s4_py_ff  <= s3_py_ff;
         s4_d1x_ff <= s3_d1x_ff;
         s4_d1y_ff <= s3_d1y_ff;
         s4_par_ff <= (s3_den_ff == '0);
         if (s3_den_ff[SW-1]) begin
            s4_den_ff <= -s3_den_ff;
            s4_tn_ff  <= -s3_tn_ff;
            s4_un_ff  <= -s3_un_ff;
         end else begin
            s4_den_ff <= s3_den_ff;
            s4_tn_ff  <= s3_tn_ff;
            s4_un_ff  <= s3_un_ff;
         end
      end
   end

   // ---------------- stage 5: den*tol and tn*d1 ----------------
   logic signed [CW-1:0]  s5_px_ff, s5_py_ff;
   logic signed [SW-1:0]  s5_den_ff, s5_tn_ff, s5_un_ff;
   logic                  s5_par_ff;
   logic [SW+TW-2:0]      s5_dt_ff;
   logic signed [NW-1:0]  s5_nx_ff, s5_ny_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_px_ff  <= s4_px_ff;
         s5_py_ff  <= s4_py_ff;
         s5_den_ff <= s4_den_ff;
         s5_tn_ff  <= s4_tn_ff;
         s5_un_ff  <= s4_un_ff;
         s5_par_ff <= s4_par_ff;
         s5_dt_ff  <= s4_den_ff[SW-2:0] * tol_ff;
         s5_nx_ff  <= s4_tn_ff * s4_d1x_ff;
         s5_ny_ff  <= s4_tn_ff * s4_d1y_ff;
      end
   end

   // ---------------- stage 6: range check, offset magnitude ----------------
   // t in range: tn*2^16 >= -den*tol and den*2^16 + den*tol >= tn*2^16
   logic signed [HW-1:0] dt_s, hi_b, tn_s, un_s;
   logic                 t_ok, u_ok;

   assign dt_s = HW'(s5_dt_ff);
   assign hi_b = {{(HW-SW-TW){s5_den_ff[SW-1]}}, s5_den_ff, {TW{1'b0}}} + dt_s;
   assign tn_s = {{(HW-SW-TW){s5_tn_ff[SW-1]}}, s5_tn_ff, {TW{1'b0}}};
   assign un_s = {{(HW-SW-TW){s5_un_ff[SW-1]}}, s5_un_ff, {TW{1'b0}}};
   assign t_ok = (tn_s >= -dt_s) && (hi_b >= tn_s);
   assign u_ok = (un_s >= -dt_s) && (hi_b >= un_s);

   logic signed [CW-1:0] s6_px_ff, s6_py_ff;
   logic [SW-2:0]        s6_den_ff;
   logic                 s6_par_ff, s6_hit_ff, s6_negx_ff, s6_negy_ff;
   logic [NW-1:0]        s6_magx_ff, s6_magy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_px_ff   <= s5_px_ff;
         s6_py_ff   <= s5_py_ff;
         s6_den_ff  <= s5_den_ff[SW-2:0];
         s6_par_ff  <= s5_par_ff;
         s6_hit_ff  <= t_ok && u_ok;
         s6_negx_ff <= s5_nx_ff[NW-1];
         s6_negy_ff <= s5_ny_ff[NW-1];
         s6_magx_ff <= s5_nx_ff[NW-1] ? NW'(-s5_nx_ff) : NW'(s5_nx_ff);
         s6_magy_ff <= s5_ny_ff[NW-1] ? NW'(-s5_ny_ff) : NW'(s5_ny_ff);
      end
   end

   // ---------------- stage 7: dividend 2|n| + den ----------------
   side_type      s7_side_ff;
   logic [SW-2:0] s7_den_ff;
   logic [RW-1:0] s7_numx_ff, s7_numy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s7_side_ff <= '{par: s6_par_ff, hit: s6_hit_ff, negx: s6_negx_ff,
                         negy: s6_negy_ff, px: s6_px_ff, py: s6_py_ff};
         s7_den_ff  <= s6_den_ff;
         s7_numx_ff <= RW'({s6_magx_ff, 1'b0}) + RW'(s6_den_ff);
         s7_numy_ff <= RW'({s6_magy_ff, 1'b0}) + RW'(s6_den_ff);
      end
   end

   // ---------------- divider lanes ----------------
   logic [QB-1:0] qx_w, qy_w;

   sli_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (s7_numx_ff),
      .den   (s7_den_ff),
      .quot  (qx_w)
   );

   sli_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (s7_numy_ff),
      .den   (s7_den_ff),
      .quot  (qy_w)
   );

   // sideband delay matching the divider
   side_type side_ff [QB];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= s7_side_ff;
         for (int k = 1; k < QB; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- output: apply offset and saturate ----------------
   side_type            sd;
   logic signed [VW-1:0] vx, vy;
   logic [CW-1:0]        ox, oy;

   assign sd = side_ff[QB-1];
   assign vx = sd.negx ? VW'(signed'(sd.px)) + VW'(qx_w) : VW'(signed'(sd.px)) - VW'(qx_w);
   assign vy = sd.negy ? VW'(signed'(sd.py)) + VW'(qy_w) : VW'(signed'(sd.py)) - VW'(qy_w);

   function automatic logic [CW-1:0] sat(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] maxv;
      logic signed [VW-1:0] minv;
      maxv = VW'({1'b0, {(CW-1){1'b1}}});
      minv = -maxv - VW'(1);
      if (v > maxv) begin
         sat = maxv[CW-1:0];
      end else if (v < minv) begin
         sat = minv[CW-1:0];
      end else begin
         sat = v[CW-1:0];
      end
   endfunction

   assign ox = sat(vx);
   assign oy = sat(vy);

   logic          o_hit_ff, o_par_ff;
   logic [CW-1:0] o_x_ff, o_y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         o_par_ff <= sd.par;
         o_hit_ff <= sd.hit && !sd.par;
         o_x_ff   <= sd.par ? '0 : ox;
         o_y_ff   <= sd.par ? '0 : oy;
      end
   end

   assign rsp_tvalid = val_ff[NV-1];
   assign rsp_tdata  = RSP_W'({o_y_ff, o_x_ff, o_par_ff, o_hit_ff});

endmodule

`default_nettype wire

>>> rtl/sli_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sli_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic [sli_pkg::RSP_W-1:0]   rsp_tdata,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready
);
   import sli_pkg::*;

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // parallel result carries no hit and a zero point
   a_par: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0] && rsp_tdata[2 +: 2*CW] == '0)
      else $error("parallel result not cleared");

   // pipe empties on reset
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // downstream ready never blocks the input side
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled with output ready");

   logic unused_req;
   assign unused_req = req_tvalid;

endmodule

bind segment_line_intersection sli_chk u_sli_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

>>> tb/sli_checker.sv
`timescale 1ns / 1ps

module sli_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [sli_pkg::REQ_W-1:0]   req_tdata,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [sli_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [sli_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   input  wire logic                        csr_pready,
   output int                               fail_count,
   output int                               pending
);
   import sli_pkg::*;

   typedef struct {
      logic          hit;
      logic          par;
      logic [CW-1:0] px;
      logic [CW-1:0] py;
   } crossing_type;

   localparam longint ONE_Q16 = 65536;
   localparam longint OFF_CLAMP = longint'(1) << 40;
   localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint CMIN = -CMAX - 1;

   logic [TW-1:0] tol_q;
   crossing_type  crossing_q[$];

   function automatic bit within_unit(longint num, longint den, longint tol);
      longint s;
      s = num * ONE_Q16;
      return (s >= -(den * tol)) && (s <= den * (ONE_Q16 + tol));
   endfunction

   function automatic logic [CW-1:0] round_point(longint start, longint tn, longint d,
                                                 longint den);
      longint n, q, v;
      bit     neg;
      n = tn * d;
      neg = n < 0;
      if (neg) n = -n;
      q = (2 * n + den) / (2 * den);   // halves away from zero
      if (q > OFF_CLAMP) q = OFF_CLAMP;
      v = neg ? start + q : start - q;
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return v[CW-1:0];
   endfunction

   function automatic crossing_type predict_crossing(logic [REQ_W-1:0] d, logic [TW-1:0] tol);
      longint       c[8];
      longint       d1x, d1y, d2x, d2y, ex, ey, den, tn, un, t;
      crossing_type r;
      for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[i*CW +: CW]));
      d1x = c[0] - c[2]; d1y = c[1] - c[3];
      d2x = c[4] - c[6]; d2y = c[5] - c[7];
      ex  = c[0] - c[4]; ey  = c[1] - c[5];
      den = d1x * d2y - d1y * d2x;
      tn  = ex * d2y - ey * d2x;
      un  = d1y * ex - d1x * ey;
      t   = longint'({48'b0, tol});
      r = '{hit: 1'b0, par: 1'b1, px: '0, py: '0};
      if (den != 0) begin
         if (den < 0) begin
            den = -den; tn = -tn; un = -un;
         end
         r.par = 1'b0;
         r.hit = within_unit(tn, den, t) && within_unit(un, den, t);
         r.px  = round_point(c[0], tn, d1x, den);
         r.py  = round_point(c[1], tn, d1y, den);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      crossing_type e;
      logic [CW-1:0] gx, gy;
      if (reset) begin
         tol_q <= TOL_RESET;
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[CSR_AW-1:2] == REG_TOLERANCE)
            tol_q <= csr_pwdata[TW-1:0];
         if (rsp_tvalid && rsp_tready) begin
            gx = rsp_tdata[2 +: CW];
            gy = rsp_tdata[2 + CW +: CW];
            if (crossing_q.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               fail_count++;
            end else begin
               e = crossing_q.pop_front();
               if (rsp_tdata[0] !== e.hit) begin
                  $error("hit: expected %0d, got %0d", e.hit, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[1] !== e.par) begin
                  $error("parallel: expected %0d, got %0d", e.par, rsp_tdata[1]);
                  fail_count++;
               end
               if (gx !== e.px) begin
                  $error("point_x: expected %0d, got %0d", $signed(e.px), $signed(gx));
                  fail_count++;
               end
               if (gy !== e.py) begin
                  $error("point_y: expected %0d, got %0d", $signed(e.py), $signed(gy));
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) crossing_q.push_back(predict_crossing(req_tdata, tol_q));
      end
      pending = crossing_q.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sli_pkg::*;

   localparam int IDLE_LIMIT = 5000;     // cycles without any transfer
   localparam int DRAIN_WAIT = 30;       // pipe is 26 deep
   localparam logic [CSR_AW-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};
   localparam logic [CSR_AW-1:0] SPARE_ADDR = CSR_AW'(4);   // no register here

   logic clock = 1'b0;
   logic reset = 1'b1;

   // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
   // line_start_x, line_start_y, line_end_x, line_end_y
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // hit, parallel, point_x, point_y, pad
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             csr_psel = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   int fail_count;
   int pending;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   segment_line_intersection u_dut (.*);

   sli_checker u_checker (.*);

   // Receiver: modes of full flow, coin-flip ready, and ready with stall runs.
   int rx_mode = 0;
   int rx_left = 0;
   int rx_stall = 0;
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 2);
         rx_left <= $urandom_range(64, 256);
      end else begin
         rx_left <= rx_left - 1;
      end
      if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall <= rx_stall - 1;
      end else if (rx_mode == 0) begin
         rsp_tready <= 1'b1;
      end else if (rx_mode == 1) begin
         rsp_tready <= 1'($urandom_range(0, 1));
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 15) == 0) rx_stall <= $urandom_range(1, 20);
      end
   end

   // watchdog: only counts cycles in which no transfer happens
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [REQ_W-1:0] pack_pair(int px, int py, int qx, int qy,
                                                  int ax, int ay, int bx, int by);
      return {CW'(by), CW'(bx), CW'(ay), CW'(ax), CW'(qy), CW'(qx), CW'(py), CW'(px)};
   endfunction

   function automatic int span(int s);
      return int'($urandom_range(0, 2 * s)) - s;
   endfunction

   // random pair, weighted toward shapes that actually cross
   function automatic logic [REQ_W-1:0] random_pair();
      int k, px, py, qx, qy, ox, oy;
      logic [REQ_W-1:0] d;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         d = pack_pair(span(100), span(100), span(100), span(100),
                       span(100), span(100), span(100), span(100));
      end else if (k < 65) begin
         for (int i = 0; i < REQ_W / 32; i++) d[i*32 +: 32] = $urandom;
      end else if (k < 75) begin
         // shifted or collinear copy: zero denominator
         px = span(3000); py = span(3000); qx = span(3000); qy = span(3000);
         ox = span(2000); oy = ($urandom_range(0, 1)) ? span(2000) : 0;
         if ($urandom_range(0, 1)) begin
            ox = 0; oy = 0;
         end
         d = pack_pair(px, py, qx, qy, px + ox, py + oy, qx + ox, qy + oy);
      end else if (k < 85) begin
         // long lines spanning nearly the full x range
         d = pack_pair(-32768 + span(500), span(30000), 32767 - $urandom_range(0, 500),
                       span(30000), -32768 + $urandom_range(0, 500), span(30000),
                       32767 - $urandom_range(0, 500), span(30000));
      end else if (k < 90) begin
         // degenerate first segment
         px = span(32767); py = span(32767);
         d = pack_pair(px, py, px, py, span(32767), span(32767), span(32767), span(32767));
      end else begin
         d = pack_pair(span(20000), span(20000), span(20000), span(20000),
                       span(20000), span(20000), span(20000), span(20000));
      end
      return d;
   endfunction

   task automatic send_pair(logic [REQ_W-1:0] d);
      req_tdata <= d;
      req_tvalid <= 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // bursts of back-to-back transfers separated by random gaps
   task automatic send_random(int count, bit pause_midway);
      int burst, gap;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_pair(random_pair());
            sent++;
         end
         if (pause_midway && sent >= count / 2) begin
            drain();
            pause_midway = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset tolerance
      send_pair(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_pair(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(pack_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
      send_pair(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));                // parallel
      send_pair(pack_pair(0, 0, 10, 10, 2, 2, 20, 20));              // collinear
      send_pair(pack_pair(0, 0, 1, 1, 0, 1, 1, 0));                  // +half rounds up
      send_pair(pack_pair(0, 0, -1, -1, 0, -1, -1, 0));              // -half rounds down
      send_pair(pack_pair(-10, 0, 10, 0, 0, -10, 0, 10));            // plain cross
      // t exactly at 1 + tol, one step outside it, exactly at -tol, one step outside it
      send_pair(pack_pair(-16384, 0, 16384, 0, 16417, -5, 16417, 5));
      send_pair(pack_pair(-16384, 0, 16384, 0, 16418, -5, 16418, 5));
      send_pair(pack_pair(-16384, 0, 16384, 0, -16417, -5, -16417, 5));
      send_pair(pack_pair(-16384, 0, 16384, 0, -16418, -5, -16418, 5));
      // u at the bound, roles swapped
      send_pair(pack_pair(16417, -5, 16417, 5, -16384, 0, 16384, 0));
      // far crossing of nearly parallel lines saturates
      send_pair(pack_pair(-32768, 0, 32767, 1, -32768, 2, 32767, 2));
      send_pair(pack_pair(32767, 0, -32768, -1, 32767, -2, -32768, -2));
      send_pair(pack_pair(0, -32768, 1, 32767, 2, -32768, 2, 32767));

      drain();
      csr_write(TOL_ADDR, 32'd0);
      send_pair(pack_pair(-16384, 0, 16384, 0, 16384, -5, 16384, 5));   // exact end
      send_pair(pack_pair(-16384, 0, 16384, 0, 16385, -5, 16385, 5));
      send_pair(pack_pair(-16384, 0, 16384, 0, -16384, -5, -16384, 5)); // exact start
      send_random(280, 0);

      drain();
      csr_write(TOL_ADDR, 32'hFFFF_FFFF);   // upper bits dropped: 65535
      send_random(300, 1);

      drain();
      csr_write(SPARE_ADDR, 32'd5);         // ignored
      send_pair(pack_pair(-16384, 0, 16384, 0, 32767, -5, 32767, 5));
      send_random(300, 0);

      drain();
      csr_write(TOL_ADDR, $urandom_range(0, 65535));
      send_random(300, 0);

      drain();
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> sim.f
rtl/sli_pkg.sv
rtl/sli_div.sv
rtl/segment_line_intersection.sv
rtl/sli_chk.sv
tb/sli_checker.sv
tb/tb_top.sv
